/* hdl/ils_pkg.sv */
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and constants for the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int unsigned DEPTH  = 256;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = ADDR_W + 1;
  localparam int unsigned VAL_W  = 32;

  // command codes
  localparam logic [3:0] CMD_INS_FRONT = 4'd0;
  localparam logic [3:0] CMD_INS_BACK  = 4'd1;
  localparam logic [3:0] CMD_INS_AT    = 4'd2;
  localparam logic [3:0] CMD_REM_FRONT = 4'd3;
  localparam logic [3:0] CMD_REM_BACK  = 4'd4;
  localparam logic [3:0] CMD_REM_AT    = 4'd5;
  localparam logic [3:0] CMD_READ      = 4'd6;
  localparam logic [3:0] CMD_WRITE     = 4'd7;
  localparam logic [3:0] CMD_SEARCH    = 4'd8;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINAL,
    S_RESP
  } ils_state_e;

  // memory request group from the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // physical slot of a list position
  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] front,
                                                input logic [CNT_W-1:0]  pos);
    return front + pos[ADDR_W-1:0];
  endfunction

endpackage

/* hdl/ils_ram.sv */
// ----------------------------------------------------------------------------
// ils_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ils_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/ils_ctrl.sv */
// ----------------------------------------------------------------------------
// ils_ctrl
// Command sequencer: front/count registers, shift and search walks over the
// element RAM, result register.
// ----------------------------------------------------------------------------
module ils_ctrl import ils_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  logic [3:0]       command_i,
  input  logic [CNT_W-1:0] index_i,
  input  logic [VAL_W-1:0] value_i,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output logic [1:0]       status_o,
  output logic [VAL_W-1:0] read_value_o,
  output logic             found_o,
  output logic [CNT_W-1:0] count_o,
  output mem_req_t         mem_req_o,
  input  logic [VAL_W-1:0] mem_rdata_i
);

  ils_state_e        state_q, state_d;
  logic [3:0]        cmd_q, cmd_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic [CNT_W-1:0]  src_q, src_d;
  logic              more_q, more_d;
  logic              pend_q, pend_d;
  logic [CNT_W-1:0]  pend_pos_q, pend_pos_d;
  logic [ADDR_W-1:0] front_q, front_d;
  logic [CNT_W-1:0]  count_q, count_d;
  status_e           status_q, status_d;
  logic              found_q, found_d;
  logic [VAL_W-1:0]  rdval_q, rdval_d;
  logic              m_valid_q, m_valid_d;
  logic [1:0]        m_status_q, m_status_d;
  logic [VAL_W-1:0]  m_rdval_q, m_rdval_d;
  logic              m_found_q, m_found_d;
  logic [CNT_W-1:0]  m_count_q, m_count_d;

  logic full, empty, up;

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);
  assign up    = (cmd_q == CMD_INS_AT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      front_q   <= '0;
      count_q   <= '0;
      more_q    <= 1'b0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      front_q   <= front_d;
      count_q   <= count_d;
      more_q    <= more_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    idx_q      <= idx_d;
    val_q      <= val_d;
    src_q      <= src_d;
    pend_pos_q <= pend_pos_d;
    status_q   <= status_d;
    found_q    <= found_d;
    rdval_q    <= rdval_d;
    m_status_q <= m_status_d;
    m_rdval_q  <= m_rdval_d;
    m_found_q  <= m_found_d;
    m_count_q  <= m_count_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    idx_d      = idx_q;
    val_d      = val_q;
    src_d      = src_q;
    more_d     = more_q;
    pend_d     = pend_q;
    pend_pos_d = pend_pos_q;
    front_d    = front_q;
    count_d    = count_q;
    status_d   = status_q;
    found_d    = found_q;
    rdval_d    = rdval_q;
    m_valid_d  = m_valid_q & ~m_ready_i;
    m_status_d = m_status_q;
    m_rdval_d  = m_rdval_q;
    m_found_d  = m_found_q;
    m_count_d  = m_count_q;
    mem_req_o  = '0;
    s_ready_o  = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_d    = command_i;
          idx_d    = index_i;
          val_d    = value_i;
          status_d = ST_OK;
          found_d  = 1'b0;
          rdval_d  = '0;
          pend_d   = 1'b0;
          more_d   = 1'b0;
          state_d  = S_RESP;
          unique case (command_i)
            CMD_INS_FRONT: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                front_d         = front_q - ADDR_W'(1);
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = front_q - ADDR_W'(1);
                mem_req_o.wdata = value_i;
                count_d         = count_q + CNT_W'(1);
              end
            end
            CMD_INS_BACK: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = slot_of(front_q, count_q);
                mem_req_o.wdata = value_i;
                count_d         = count_q + CNT_W'(1);
              end
            end
            CMD_INS_AT: begin
              if (index_i > count_q) begin
                status_d = ST_RANGE;
              end else if (full) begin
                status_d = ST_FULL;
              end else begin
                src_d   = count_q - CNT_W'(1);
                more_d  = (count_q != index_i);
                state_d = S_SCAN;
              end
            end
            CMD_REM_FRONT: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                front_d = front_q + ADDR_W'(1);
                count_d = count_q - CNT_W'(1);
              end
            end
            CMD_REM_BACK: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                count_d = count_q - CNT_W'(1);
              end
            end
            CMD_REM_AT: begin
              if (index_i >= count_q) begin
                status_d = ST_RANGE;
              end else begin
                src_d   = index_i + CNT_W'(1);
                more_d  = ((index_i + CNT_W'(1)) != count_q);
                state_d = S_SCAN;
              end
            end
            CMD_READ: begin
              if (index_i >= count_q) begin
                status_d = ST_RANGE;
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = slot_of(front_q, index_i);
                state_d         = S_FINAL;
              end
            end
            CMD_WRITE: begin
              if (index_i >= count_q) begin
                status_d = ST_RANGE;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = slot_of(front_q, index_i);
                mem_req_o.wdata = value_i;
              end
            end
            CMD_SEARCH: begin
              src_d   = '0;
              more_d  = !empty;
              state_d = S_SCAN;
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        // retire the element read last cycle
        if (pend_q) begin
          if (cmd_q == CMD_SEARCH) begin
            if (mem_rdata_i == val_q) begin
              found_d = 1'b1;
            end
          end else begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = slot_of(front_q, pend_pos_q);
            mem_req_o.wdata = mem_rdata_i;
          end
        end
        if (more_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = slot_of(front_q, src_q);
          pend_d          = 1'b1;
          if (up) begin
            pend_pos_d = src_q + CNT_W'(1);
            src_d      = src_q - CNT_W'(1);
            more_d     = (src_q != idx_q);
          end else begin
            pend_pos_d = src_q - CNT_W'(1);
            src_d      = src_q + CNT_W'(1);
            more_d     = ((src_q + CNT_W'(1)) != count_q);
          end
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (up) begin
              state_d = S_FINAL;
            end else begin
              if (cmd_q == CMD_REM_AT) begin
                count_d = count_q - CNT_W'(1);
              end
              state_d = S_RESP;
            end
          end
        end
      end

      S_FINAL: begin
        if (cmd_q == CMD_READ) begin
          rdval_d = mem_rdata_i;
        end else begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = slot_of(front_q, idx_q);
          mem_req_o.wdata = val_q;
          count_d         = count_q + CNT_W'(1);
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!m_valid_q || m_ready_i) begin
          m_valid_d  = 1'b1;
          m_status_d = status_q;
          m_rdval_d  = rdval_q;
          m_found_d  = found_q;
          m_count_d  = count_q;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign m_valid_o    = m_valid_q;
  assign status_o     = m_status_q;
  assign read_value_o = m_rdval_q;
  assign found_o      = m_found_q;
  assign count_o      = m_count_q;

endmodule

/* hdl/indexed_list_store_top.sv */
// ----------------------------------------------------------------------------
// indexed_list_store_top
// Ordered list of up to DEPTH signed 32-bit values in a circular RAM.
// ----------------------------------------------------------------------------
// One input transaction is one command; it returns exactly one result
// transaction. The block handles one command at a time: s_axis_tready_o is
// high only while the sequencer is idle, and the result sits in an output
// register so the next command can be taken while it waits. Indexed insert,
// indexed remove and search walk the element RAM; the walks are set by the
// single read port of the element RAM, one element per cycle, with the
// write-back of each moved element pipelined behind the next read and a
// final step to retire the last one. The RAM contents are not cleared after
// reset; only positions inside the list are ever read, so no clearing pass
// is needed.
module indexed_list_store_top import ils_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // [8:0] index, [40:9] value, rest zero
  input  logic [3:0]  s_axis_tuser_i,   // [3:0] command
  // master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [31:0] read_value, [32] found,
                                        // [41:33] count, rest zero
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  mem_req_t         mem_req;
  logic [VAL_W-1:0] mem_rdata;
  logic [VAL_W-1:0] rd_value;
  logic             found;
  logic [CNT_W-1:0] count;

  // element store: circular, addressed from the front pointer
  ils_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // command sequencer and result register
  ils_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .command_i    (s_axis_tuser_i),
    .index_i      (s_axis_tdata_i[CNT_W-1:0]),
    .value_i      (s_axis_tdata_i[CNT_W+VAL_W-1:CNT_W]),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .status_o     (m_axis_tuser_o),
    .read_value_o (rd_value),
    .found_o      (found),
    .count_o      (count),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata)
  );

  assign m_axis_tdata_o = {6'b0, count, found, rd_value};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // one command in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("command accepted while another is in flight");

  // no RAM traffic while idle without a command
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o && !s_axis_tvalid_i |-> !mem_req.we && !mem_req.re)
    else $error("RAM access while idle");

  // reported count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> count <= CNT_W'(DEPTH))
    else $error("count above capacity");

  // a full rejection only happens with a full list
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_FULL) |-> count == CNT_W'(DEPTH))
    else $error("full status with room left");

  // an empty rejection only happens with an empty list
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_EMPTY) |-> count == '0)
    else $error("empty status on a non-empty list");

endmodule

/* bench/tb_indexed_list_store_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_store_top
// Self-checking bench for the indexed list store.
// ----------------------------------------------------------------------------
// Commands go in as stream transactions. A shadow copy of the list (front slot,
// count, element array) is updated at every accepted command, and it yields the
// expected status, read data, found flag and count. Each result transaction is
// compared field by field against the oldest expected result. The tests cover
// the empty list, every command, the extreme values and indexes, a full list
// with the longest walks, a long output hold-off, and a long random mix.
// ----------------------------------------------------------------------------
module tb_indexed_list_store_top;
  import ils_pkg::*;

  localparam int unsigned TDATA_W      = 48;
  localparam int unsigned IDX_MAX      = (1 << CNT_W) - 1;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned MAX_MSGS     = 20;
  // codes 9..15 have no command behind them
  localparam logic [3:0]  CMD_FIRST_UNUSED = CMD_SEARCH + 4'd1;
  localparam logic [3:0]  CMD_LAST_CODE    = 4'hF;

  typedef struct packed {
    status_e          status;
    logic [VAL_W-1:0] read_value;
    logic             found;
    logic [CNT_W-1:0] count;
  } list_result_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [TDATA_W-1:0] s_axis_tdata_i  = '0;
  logic [3:0]         s_axis_tuser_i  = '0;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata_o;
  logic [1:0]         m_axis_tuser_o;

  // shadow copy of the list, advanced at each accepted command
  logic [VAL_W-1:0]   shadow_elems [DEPTH];
  int unsigned        shadow_front = 0;
  int unsigned        shadow_count = 0;

  list_result_t       expected_results [$];
  int unsigned        mismatch_count = 0;
  int unsigned        result_serial  = 0;
  int unsigned        quiet_cycles   = 0;
  bit                 gaps_on        = 1'b1;
  bit                 hold_pending   = 1'b0;

  indexed_list_store_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // [8:0] index, [40:9] value, rest zero
    .s_axis_tuser_i  (s_axis_tuser_i),   // [3:0] command
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [31:0] read_value, [32] found, [41:33] count
    .m_axis_tuser_o  (m_axis_tuser_o)    // [1:0] status
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shadow list
  // --------------------------------------------------------------------------
  function automatic int unsigned list_slot(input int unsigned pos);
    return (shadow_front + pos) % DEPTH;
  endfunction

  // open a gap at pos by moving the tail back one slot
  function automatic void shift_in(input int unsigned pos, input logic [VAL_W-1:0] val);
    int unsigned i;
    for (i = shadow_count; i > pos; i--)
      shadow_elems[list_slot(i)] = shadow_elems[list_slot(i - 1)];
    shadow_elems[list_slot(pos)] = val;
    shadow_count++;
  endfunction

  // apply one command to the shadow list and return the result it must produce
  function automatic list_result_t apply_list_cmd(input logic [3:0]       cmd,
                                                  input logic [CNT_W-1:0] idx,
                                                  input logic [VAL_W-1:0] val);
    list_result_t res;
    int unsigned  pos;
    int unsigned  i;
    bit           is_full;
    res     = '{status: ST_OK, read_value: '0, found: 1'b0, count: '0};
    pos     = 32'(idx);
    is_full = (shadow_count >= DEPTH);
    case (cmd)
      CMD_INS_FRONT: begin
        if (is_full) begin
          res.status = ST_FULL;
        end else begin
          shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
          shadow_elems[shadow_front] = val;
          shadow_count++;
        end
      end
      CMD_INS_BACK: begin
        if (is_full) res.status = ST_FULL;
        else shift_in(shadow_count, val);
      end
      CMD_INS_AT: begin
        // range check wins over the full check
        if (pos > shadow_count) res.status = ST_RANGE;
        else if (is_full) res.status = ST_FULL;
        else shift_in(pos, val);
      end
      CMD_REM_FRONT: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          shadow_front = (shadow_front + 1) % DEPTH;
          shadow_count--;
        end
      end
      CMD_REM_BACK: begin
        if (shadow_count == 0) res.status = ST_EMPTY;
        else shadow_count--;
      end
      CMD_REM_AT: begin
        if (pos >= shadow_count) begin
          res.status = ST_RANGE;
        end else begin
          for (i = pos; i + 1 < shadow_count; i++)
            shadow_elems[list_slot(i)] = shadow_elems[list_slot(i + 1)];
          shadow_count--;
        end
      end
      CMD_READ: begin
        if (pos >= shadow_count) res.status = ST_RANGE;
        else res.read_value = shadow_elems[list_slot(pos)];
      end
      CMD_WRITE: begin
        if (pos >= shadow_count) res.status = ST_RANGE;
        else shadow_elems[list_slot(pos)] = val;
      end
      CMD_SEARCH: begin
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_elems[list_slot(i)] == val) begin
            res.found = 1'b1;
            break;
          end
        end
      end
      default: ;
    endcase
    res.count = shadow_count[CNT_W-1:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // drive one command and hold it until the block takes it
  task automatic issue_command(input logic [3:0]       cmd,
                               input logic [CNT_W-1:0] idx,
                               input logic [VAL_W-1:0] val);
    while (gaps_on && $urandom_range(99) < 7) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {{(TDATA_W - VAL_W - CNT_W){1'b0}}, val, idx};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_results.push_back(apply_list_cmd(cmd, idx, val));
  endtask

  task automatic wait_for_results();
    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // extremes and a narrow range (to get duplicates and search hits) mixed in
  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 4) return 32'h8000_0000;
    if (roll < 8) return 32'h7FFF_FFFF;
    if (roll < 11) return 32'hFFFF_FFFF;
    if (roll < 14) return '0;
    if (roll < 34) return $urandom_range(15);
    return $urandom;
  endfunction

  task automatic report_mismatch(input string text);
    if (mismatch_count < MAX_MSGS) $display("ERROR @%0t: %s", $realtime, text);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // every command but front and back insert on the empty list, plus the unused codes
  task automatic test_empty_list();
    issue_command(CMD_REM_FRONT, '0, '0);
    issue_command(CMD_REM_BACK, CNT_W'(IDX_MAX), '1);
    issue_command(CMD_REM_AT, '0, '0);
    issue_command(CMD_READ, '0, '0);
    issue_command(CMD_WRITE, '0, 32'h1234_5678);
    issue_command(CMD_SEARCH, '0, '0);
    issue_command(CMD_INS_AT, 9'd1, 32'hDEAD_BEEF);
    issue_command(CMD_FIRST_UNUSED, '0, '1);
    issue_command(CMD_LAST_CODE, CNT_W'(IDX_MAX), '1);
  endtask

  // each command with success, range errors for the indexed ones, extreme values and indexes
  task automatic test_basic_commands();
    issue_command(CMD_INS_BACK, '0, 32'h7FFF_FFFF);
    issue_command(CMD_INS_FRONT, '0, 32'h8000_0000);
    issue_command(CMD_INS_AT, 9'd1, 32'hFFFF_FFFF);
    issue_command(CMD_INS_AT, 9'd3, '0);            // index equal to count
    issue_command(CMD_INS_AT, CNT_W'(IDX_MAX), 32'h0BAD_0BAD);
    issue_command(CMD_READ, '0, '0);
    issue_command(CMD_READ, 9'd3, '0);
    issue_command(CMD_READ, CNT_W'(DEPTH), '0);
    issue_command(CMD_WRITE, 9'd2, 32'h5555_5555);
    issue_command(CMD_WRITE, CNT_W'(IDX_MAX), 32'hAAAA_AAAA);
    issue_command(CMD_SEARCH, '0, 32'h5555_5555);
    issue_command(CMD_SEARCH, '0, 32'hAAAA_AAAA);
    issue_command(CMD_REM_AT, 9'd1, '0);
    issue_command(CMD_REM_AT, 9'd3, '0);
    issue_command(CMD_REM_FRONT, '0, '0);
    issue_command(CMD_REM_BACK, '0, '0);
    issue_command(CMD_REM_AT, '0, '0);
  endtask

  // fill to DEPTH, hit the full cases and the longest walks, then drain to four elements
  task automatic test_full_list();
    while (shadow_count < DEPTH) begin
      case ($urandom_range(2))
        0: issue_command(CMD_INS_FRONT, CNT_W'($urandom_range(IDX_MAX)), pick_value());
        1: issue_command(CMD_INS_BACK, CNT_W'($urandom_range(IDX_MAX)), pick_value());
        default: issue_command(CMD_INS_AT, CNT_W'($urandom_range(shadow_count, 0)),
                               pick_value());
      endcase
    end
    issue_command(CMD_INS_FRONT, '0, pick_value());
    issue_command(CMD_INS_BACK, '0, pick_value());
    issue_command(CMD_INS_AT, CNT_W'(DEPTH), pick_value());
    issue_command(CMD_INS_AT, CNT_W'(DEPTH + 1), pick_value());
    issue_command(CMD_INS_AT, '0, pick_value());
    issue_command(CMD_SEARCH, '0, shadow_elems[list_slot(DEPTH - 1)]);
    issue_command(CMD_SEARCH, '0, $urandom);
    issue_command(CMD_READ, CNT_W'(DEPTH - 1), '0);
    issue_command(CMD_WRITE, CNT_W'(DEPTH - 1), $urandom);
    issue_command(CMD_READ, CNT_W'(DEPTH), '0);
    issue_command(CMD_REM_AT, CNT_W'(DEPTH), '0);
    issue_command(CMD_REM_AT, '0, '0);
    issue_command(CMD_INS_AT, '0, pick_value());
    issue_command(CMD_READ, '0, '0);
    while (shadow_count > 4) begin
      case ($urandom_range(2))
        0: issue_command(CMD_REM_FRONT, CNT_W'($urandom_range(IDX_MAX)), '0);
        1: issue_command(CMD_REM_BACK, CNT_W'($urandom_range(IDX_MAX)), '0);
        default: issue_command(CMD_REM_AT, CNT_W'($urandom_range(shadow_count - 1, 0)),
                               '0);
      endcase
    end
  endtask

  // result side stalls for a long stretch while commands keep coming
  task automatic test_output_backpressure();
    int unsigned k;
    gaps_on      = 1'b0;
    hold_pending = 1'b1;
    for (k = 0; k < 40; k++) begin
      case (k % 3)
        0: issue_command(CMD_INS_BACK, '0, pick_value());
        1: issue_command(CMD_READ, CNT_W'($urandom_range(shadow_count)), '0);
        default: issue_command(CMD_SEARCH, '0, pick_value());
      endcase
    end
    gaps_on = 1'b1;
  endtask

  // random commands; the list size follows a moving target, mostly small
  task automatic test_random_mix(input int unsigned n_items);
    int unsigned      k;
    int unsigned      target;
    int unsigned      roll;
    bit               grow;
    logic [3:0]       cmd;
    logic [CNT_W-1:0] idx;
    logic [VAL_W-1:0] val;
    target = 8;
    for (k = 0; k < n_items; k++) begin
      if (k % 50 == 0)
        target = ($urandom_range(9) == 0) ? $urandom_range(96, 32) : $urandom_range(20);
      gaps_on = !(k >= 200 && k < 350);   // a stretch with no idling on either side
      roll = $urandom_range(99);
      if (roll < 64) begin
        grow = (shadow_count < target) ? ($urandom_range(9) < 8) : ($urandom_range(9) < 2);
        case ($urandom_range(2))
          0: cmd = grow ? CMD_INS_FRONT : CMD_REM_FRONT;
          1: cmd = grow ? CMD_INS_BACK : CMD_REM_BACK;
          default: cmd = grow ? CMD_INS_AT : CMD_REM_AT;
        endcase
      end else if (roll < 95) begin
        case ($urandom_range(2))
          0: cmd = CMD_READ;
          1: cmd = CMD_WRITE;
          default: cmd = CMD_SEARCH;
        endcase
      end else begin
        cmd = 4'($urandom_range(int'(CMD_LAST_CODE), int'(CMD_FIRST_UNUSED)));
      end
      if ($urandom_range(99) < 12) idx = CNT_W'($urandom_range(IDX_MAX));
      else if (cmd == CMD_INS_AT) idx = CNT_W'($urandom_range(shadow_count));
      else idx = (shadow_count == 0) ? '0 : CNT_W'($urandom_range(shadow_count - 1));
      val = pick_value();
      if (cmd == CMD_SEARCH && shadow_count != 0 && $urandom_range(1) == 1)
        val = shadow_elems[list_slot($urandom_range(shadow_count - 1))];
      issue_command(cmd, idx, val);
    end
    gaps_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready_i <= !(gaps_on && $urandom_range(99) < 7);
    end
  end

  // compare each result transaction with the oldest expected result
  always @(posedge clk_i) begin : result_check
    list_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      result_serial++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none expected", result_serial));
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser_o !== want.status)
          report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                    result_serial, m_axis_tuser_o, want.status));
        if (m_axis_tdata_o[31:0] !== want.read_value)
          report_mismatch($sformatf("result %0d read_value %h, expected %h",
                                    result_serial, m_axis_tdata_o[31:0], want.read_value));
        if (m_axis_tdata_o[32] !== want.found)
          report_mismatch($sformatf("result %0d found %b, expected %b",
                                    result_serial, m_axis_tdata_o[32], want.found));
        if (m_axis_tdata_o[41:33] !== want.count)
          report_mismatch($sformatf("result %0d count %0d, expected %0d",
                                    result_serial, m_axis_tdata_o[41:33], want.count));
      end
    end
  end

  // ends a hung run: too many cycles without any transaction on either side
  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    wait_for_results();
    test_basic_commands();
    wait_for_results();
    test_full_list();
    wait_for_results();
    test_output_backpressure();
    wait_for_results();
    test_random_mix(600);
    wait_for_results();
    // longest command is a walk over the whole list
    repeat (DEPTH + 16) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/ils_pkg.sv
hdl/ils_ram.sv
hdl/ils_ctrl.sv
hdl/indexed_list_store_top.sv
bench/tb_indexed_list_store_top.sv
